// ===== hdl/zrld_pkg.sv =====
// Shared types and constants for the zero run-length decoder.
package zrld_pkg;

    // Decoder phase
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_CHUNK  = 2'd2
    } phase_t;

    // Length byte positions
    localparam logic [2:0] LS_FIRST  = 3'd0;
    localparam logic [2:0] LS_W_HI   = 3'd1;
    localparam logic [2:0] LS_W_LO   = 3'd2;
    localparam logic [2:0] LS_L_B3   = 3'd3;
    localparam logic [2:0] LS_L_B2   = 3'd4;
    localparam logic [2:0] LS_L_B1   = 3'd5;
    localparam logic [2:0] LS_L_B0   = 3'd6;

    localparam logic [7:0]  ZERO_BYTE = 8'h00;
    localparam logic [31:0] COUNT_ONE = 32'd1;

    // One decoded result
    typedef struct packed {
        logic [7:0]  value;
        logic [31:0] repeat_count;
        logic        is_header;
    } result_t;

endpackage

// ===== hdl/zrld_core.sv =====
// Decoder state and per-byte decode logic.
module zrld_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_mode,
    input  logic             accept,
    input  logic [7:0]       raw_byte,
    output logic             emit,
    output zrld_pkg::result_t res
);

    logic              mode_reg;
    zrld_pkg::phase_t  phase_reg, phase_next;
    logic              in_chunk_reg, in_chunk_next;
    logic [2:0]        stage_reg, stage_next;
    logic [31:0]       acc_reg, acc_next;
    logic [31:0]       remaining_reg, remaining_next;

    logic              len_done;
    logic [31:0]       len_val;
    logic [15:0]       word_len;
    logic [31:0]       remaining_dec;

    assign word_len      = {acc_reg[7:0], raw_byte};
    assign remaining_dec = remaining_reg - 32'd1;

    // Decode one byte
    always_comb
    begin
        phase_next     = phase_reg;
        in_chunk_next  = in_chunk_reg;
        stage_next     = stage_reg;
        acc_next       = acc_reg;
        remaining_next = remaining_reg;
        emit           = 1'b0;
        res.value        = raw_byte;
        res.repeat_count = zrld_pkg::COUNT_ONE;
        res.is_header    = 1'b0;
        len_done       = 1'b0;
        len_val        = 32'd0;

        if (!mode_reg)
        begin
            // plain pass-through, state untouched
            emit = 1'b1;
        end
        else
        begin
            case (phase_reg)
                zrld_pkg::PH_LENGTH:
                begin
                    case (stage_reg)
                        zrld_pkg::LS_W_HI:
                        begin
                            acc_next   = {24'd0, raw_byte};
                            stage_next = zrld_pkg::LS_W_LO;
                        end
                        zrld_pkg::LS_W_LO:
                        begin
                            if (word_len != 16'd0)
                            begin
                                len_done = 1'b1;
                                len_val  = {16'd0, word_len};
                            end
                            else
                            begin
                                acc_next   = 32'd0;
                                stage_next = zrld_pkg::LS_L_B3;
                            end
                        end
                        zrld_pkg::LS_L_B3, zrld_pkg::LS_L_B2, zrld_pkg::LS_L_B1:
                        begin
                            acc_next   = {acc_reg[23:0], raw_byte};
                            stage_next = stage_reg + 3'd1;
                        end
                        zrld_pkg::LS_L_B0:
                        begin
                            len_done = 1'b1;
                            len_val  = {acc_reg[23:0], raw_byte};
                        end
                        default:
                        begin
                            // first length byte; zero escapes to a 16-bit length
                            if (raw_byte != zrld_pkg::ZERO_BYTE)
                            begin
                                len_done = 1'b1;
                                len_val  = {24'd0, raw_byte};
                            end
                            else
                            begin
                                acc_next   = 32'd0;
                                stage_next = zrld_pkg::LS_W_HI;
                            end
                        end
                    endcase
                end
                zrld_pkg::PH_CHUNK:
                begin
                    emit           = 1'b1;
                    remaining_next = remaining_dec;
                    if (remaining_dec == 32'd0)
                    begin
                        phase_next    = zrld_pkg::PH_LENGTH;
                        in_chunk_next = 1'b0;
                        stage_next    = zrld_pkg::LS_FIRST;
                        acc_next      = 32'd0;
                    end
                end
                default:
                begin
                    // header byte
                    emit          = 1'b1;
                    res.is_header = 1'b1;
                    phase_next    = zrld_pkg::PH_LENGTH;
                    in_chunk_next = 1'b1;
                    stage_next    = zrld_pkg::LS_FIRST;
                    acc_next      = 32'd0;
                end
            endcase

            // complete length: start a chunk or emit a run
            if (len_done)
            begin
                stage_next = zrld_pkg::LS_FIRST;
                acc_next   = 32'd0;
                if (in_chunk_reg)
                begin
                    if (len_val != 32'd0)
                    begin
                        remaining_next = len_val;
                        phase_next     = zrld_pkg::PH_CHUNK;
                    end
                    else
                    begin
                        phase_next    = zrld_pkg::PH_LENGTH;
                        in_chunk_next = 1'b0;
                    end
                end
                else
                begin
                    phase_next    = zrld_pkg::PH_LENGTH;
                    in_chunk_next = 1'b1;
                    if (len_val != 32'd0)
                    begin
                        emit             = 1'b1;
                        res.value        = zrld_pkg::ZERO_BYTE;
                        res.repeat_count = len_val;
                    end
                end
            end
        end
    end

    // State registers; a config write restarts the stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b1;
            phase_reg     <= zrld_pkg::PH_HEADER;
            in_chunk_reg  <= 1'b1;
            stage_reg     <= zrld_pkg::LS_FIRST;
            acc_reg       <= 32'd0;
            remaining_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            mode_reg      <= cfg_mode;
            phase_reg     <= zrld_pkg::PH_HEADER;
            in_chunk_reg  <= 1'b1;
            stage_reg     <= zrld_pkg::LS_FIRST;
            acc_reg       <= 32'd0;
            remaining_reg <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            in_chunk_reg  <= in_chunk_next;
            stage_reg     <= stage_next;
            acc_reg       <= acc_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

// ===== hdl/zrld_out_reg.sv =====
// Result register with valid/ready output handshake.
module zrld_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  zrld_pkg::result_t res_in,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output zrld_pkg::result_t res_out
);

    logic              valid_reg;
    zrld_pkg::result_t res_reg;

    // free when empty or when the held result transfers this cycle
    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

endmodule

// ===== hdl/zero_run_length_decoder.sv =====
// The result is registered: out_valid rises in the cycle after the input transfer; zero-result bytes emit nothing.
// Throughput: one byte per cycle while the result register can load, set by the single
//   result register and the state update in the decode core.
// Reset (rst_n, async low): compressed mode on, header expected, result register empty.
// A config write sets the mode and restarts the stream at the header.
module zero_run_length_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  raw_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  value,
    output logic [31:0] repeat_count,
    output logic        is_header
);

    logic              accept;
    logic              emit;
    logic              can_load;
    zrld_pkg::result_t res;
    zrld_pkg::result_t res_q;

    assign cfg_ready = 1'b1;
    assign in_ready  = can_load;
    assign accept    = in_valid && can_load;

    zrld_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid),
        .cfg_mode (cfg_data),
        .accept   (accept),
        .raw_byte (raw_byte),
        .emit     (emit),
        .res      (res)
    );

    zrld_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && emit),
        .res_in    (res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (res_q)
    );

    assign value        = res_q.value;
    assign repeat_count = res_q.repeat_count;
    assign is_header    = res_q.is_header;

endmodule
